>>> rtl/tlprw_pkg.sv
`timescale 1ns / 1ps

package tlprw_pkg;

   localparam int DIM_W    = 9;
   localparam int COORD_W  = 8;
   localparam int X_W      = 10;
   localparam int QUO_W    = 10;
   localparam int POS_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int CNT_W    = 4;
   localparam int SEL_W    = 2;

   localparam logic [CNT_W-1:0] DIV_LOAD_CNT = 4'd0;
   localparam logic [CNT_W-1:0] DIV_LAST_CNT = 4'd10;
   localparam logic [CNT_W-1:0] DIV_SAVE_CNT = 4'd11;
   localparam logic [SEL_W-1:0] DIV_LAST_SEL = 2'd2;
   localparam logic [SEL_W-1:0] MUL_LAST_SEL = 2'd3;

   localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 9'd32;
   localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 9'd8;
   localparam logic [DIM_W-1:0] RST_MODULE_WIDTH  = 9'd8;
   localparam logic [DIM_W-1:0] RST_MODULE_HEIGHT = 9'd8;

   localparam logic CMD_BEGIN   = 1'b0;
   localparam logic CMD_WORD    = 1'b1;
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_BAD  = 1'b1;

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_MODULE_WIDTH  = 2'd2,
      REG_MODULE_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [SEL_W-1:0] {
      DIV_X_BY_MW  = 2'd0,
      DIV_Y_BY_MH  = 2'd1,
      DIV_SW_BY_MW = 2'd2
   } div_sel_type;

   typedef enum logic [SEL_W-1:0] {
      MUL_TILE = 2'd0,
      MUL_AREA = 2'd1,
      MUL_PART = 2'd2,
      MUL_POS  = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic             accept;
      logic             div_load;
      logic             div_step;
      logic             div_save;
      logic [SEL_W-1:0] div_sel;
      logic             mul_step;
      logic [SEL_W-1:0] mul_sel;
      logic             push;
   } cmd_type;

   typedef struct packed {
      logic need_calc;
      logic need_result;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/tlprw_ctrl.sv
`timescale 1ns / 1ps

module tlprw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tlprw_pkg::stat_type stat,
   output tlprw_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_PUSH = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [tlprw_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [tlprw_pkg::SEL_W-1:0]     sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = sel_ff;
      cmd.mul_sel = cnt_ff[tlprw_pkg::SEL_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               sel_in     = '0;
               if (stat.need_calc) begin
                  state_in = ST_DIV;
               end else if (stat.need_result) begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == tlprw_pkg::DIV_LOAD_CNT) begin
               cmd.div_load = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
            end else if (cnt_ff == tlprw_pkg::DIV_SAVE_CNT) begin
               cmd.div_save = 1'b1;
               cnt_in       = '0;
               if (sel_ff == tlprw_pkg::DIV_LAST_SEL) begin
                  state_in = ST_MUL;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff[tlprw_pkg::SEL_W-1:0] == tlprw_pkg::MUL_LAST_SEL) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

>>> rtl/tlprw_dp.sv
`timescale 1ns / 1ps

module tlprw_dp #(
   parameter int MAX_DIM = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tlprw_pkg::cmd_type                  cmd,
   output tlprw_pkg::stat_type                 stat,
   input  logic                                req_cmd,
   input  logic [tlprw_pkg::COORD_W-1:0]       req_origin_x,
   input  logic [tlprw_pkg::COORD_W-1:0]       req_origin_y,
   input  logic [tlprw_pkg::DIM_W-1:0]         req_rect_width,
   input  logic [tlprw_pkg::DIM_W-1:0]         req_rect_height,
   input  logic [tlprw_pkg::DIM_W-1:0]         req_rect_pitch,
   input  logic [tlprw_pkg::WORD_W-1:0]        req_color_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic                                rsp_status,
   output logic [tlprw_pkg::POS_W-1:0]         rsp_strip_index,
   output logic [tlprw_pkg::BYTE_W-1:0]        rsp_red,
   output logic [tlprw_pkg::BYTE_W-1:0]        rsp_green,
   output logic [tlprw_pkg::BYTE_W-1:0]        rsp_blue,
   output logic                                rsp_frame_done,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [tlprw_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int DW = tlprw_pkg::DIM_W;
   localparam int XW = tlprw_pkg::X_W;
   localparam int QW = tlprw_pkg::QUO_W;
   localparam int PW = tlprw_pkg::POS_W;
   localparam int BW = tlprw_pkg::BYTE_W;
   localparam int CW = tlprw_pkg::COORD_W;

   function automatic logic [DW-1:0] eff(input logic [DW-1:0] v);
      logic [DW-1:0] r;
      r = v;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DW'(MAX_DIM);
      end
      return r;
   endfunction

   logic [DW-1:0] sw_ff, sh_ff, mw_ff, mh_ff;
   logic [DW-1:0] eff_sw, eff_sh, eff_mw, eff_mh;

   logic          active_ff, active_in;
   logic [CW-1:0] start_ff, start_in;
   logic [DW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [DW-1:0] rows_ff, rows_in;
   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] pitch_ff, pitch_in;

   logic          res_kind_ff, res_kind_in;
   logic          res_status_ff, res_status_in;
   logic          res_done_ff, res_done_in;
   logic [BW-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [XW-1:0] x_ff, x_in;
   logic [CW-1:0] y_ff, y_in;

   logic [XW-1:0] rem_ff, quo_ff;
   logic [DW-1:0] dvs_ff;
   logic [XW-1:0] rem_sh;
   logic [XW:0]   trial;
   logic [QW-1:0] tx_ff, ty_ff, per_row_ff;
   logic [DW-1:0] rx_ff, ry_ff;

   logic [PW-1:0]   tile_ff, area_ff, part_ff, pos_ff;
   logic [PW-1:0]   mul_a, mul_b, mul_add, mul_out;
   logic [2*PW-1:0] prod_full;

   logic          out_valid_ff, out_kind_ff, out_status_ff, out_done_ff;
   logic [PW-1:0] out_pos_ff;
   logic [BW-1:0] out_red_ff, out_green_ff, out_blue_ff;

   logic [XW-1:0] sum_x, sum_y, col_next;
   logic          reject, empty, is_pix, is_last;

   assign eff_sw = eff(sw_ff);
   assign eff_sh = eff(sh_ff);
   assign eff_mw = eff(mw_ff);
   assign eff_mh = eff(mh_ff);

   assign sum_x    = XW'(req_origin_x) + XW'(req_rect_pitch);
   assign sum_y    = XW'(req_origin_y) + XW'(req_rect_height);
   assign reject   = (req_rect_width > req_rect_pitch) || (sum_x > XW'(eff_sw))
                     || (sum_y > XW'(eff_sh));
   assign empty    = (req_rect_width == '0) || (req_rect_height == '0);
   assign is_pix   = active_ff && (col_ff < width_ff);
   assign is_last  = is_pix && (rows_ff == DW'(1)) && (XW'(col_ff) + 1'b1 == XW'(width_ff));
   assign col_next = XW'(col_ff) + 1'b1;

   assign stat.need_calc   = (req_cmd == tlprw_pkg::CMD_WORD) && is_pix;
   assign stat.need_result = (req_cmd == tlprw_pkg::CMD_BEGIN) || stat.need_calc;
   assign stat.out_free    = !out_valid_ff || rsp_ready;

   always_comb begin
      active_in     = active_ff;
      start_in      = start_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rows_in       = rows_ff;
      width_in      = width_ff;
      pitch_in      = pitch_ff;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      res_done_in   = res_done_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      if (cmd.accept) begin
         if (req_cmd == tlprw_pkg::CMD_BEGIN) begin
            active_in     = !reject && !empty;
            start_in      = req_origin_x;
            col_in        = '0;
            row_in        = req_origin_y;
            rows_in       = req_rect_height;
            width_in      = req_rect_width;
            pitch_in      = req_rect_pitch;
            res_kind_in   = tlprw_pkg::KIND_STATUS;
            res_status_in = reject ? tlprw_pkg::STATUS_BAD : tlprw_pkg::STATUS_OK;
            res_done_in   = !reject && empty;
            red_in        = '0;
            green_in      = '0;
            blue_in       = '0;
         end else if (active_ff) begin
            if (is_pix) begin
               res_kind_in   = tlprw_pkg::KIND_PIXEL;
               res_status_in = tlprw_pkg::STATUS_OK;
               res_done_in   = is_last;
               red_in        = req_color_word[23:16];
               green_in      = req_color_word[15:8];
               blue_in       = req_color_word[7:0];
               x_in          = XW'(start_ff) + XW'(col_ff);
               y_in          = row_ff;
            end
            if (is_last) begin
               active_in = 1'b0;
            end else if (col_next >= XW'(pitch_ff)) begin
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               rows_in = rows_ff - 1'b1;
            end else begin
               col_in = col_next[DW-1:0];
            end
         end
      end
   end

   // Restoring divider, one quotient bit per step.
   assign rem_sh = {rem_ff[XW-2:0], quo_ff[XW-1]};
   assign trial  = {1'b0, rem_sh} - (XW+1)'(dvs_ff);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_add = '0;
      case (tlprw_pkg::mul_sel_type'(cmd.mul_sel))
         tlprw_pkg::MUL_TILE: begin
            mul_a   = PW'(per_row_ff);
            mul_b   = PW'(ty_ff);
            mul_add = PW'(tx_ff);
         end
         tlprw_pkg::MUL_AREA: begin
            mul_a = PW'(eff_mw);
            mul_b = PW'(eff_mh);
         end
         tlprw_pkg::MUL_PART: begin
            mul_a   = PW'(ry_ff);
            mul_b   = PW'(eff_mw);
            mul_add = PW'(rx_ff);
         end
         tlprw_pkg::MUL_POS: begin
            mul_a   = tile_ff;
            mul_b   = area_ff;
            mul_add = part_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;
   assign mul_out   = prod_full[PW-1:0] + mul_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff     <= tlprw_pkg::RST_SCREEN_WIDTH;
         sh_ff     <= tlprw_pkg::RST_SCREEN_HEIGHT;
         mw_ff     <= tlprw_pkg::RST_MODULE_WIDTH;
         mh_ff     <= tlprw_pkg::RST_MODULE_HEIGHT;
         active_ff <= 1'b0;
         start_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         rows_ff   <= '0;
         width_ff  <= '0;
         pitch_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (tlprw_pkg::reg_index_type'(csr_index))
               tlprw_pkg::REG_SCREEN_WIDTH:  sw_ff <= csr_wdata;
               tlprw_pkg::REG_SCREEN_HEIGHT: sh_ff <= csr_wdata;
               tlprw_pkg::REG_MODULE_WIDTH:  mw_ff <= csr_wdata;
               tlprw_pkg::REG_MODULE_HEIGHT: mh_ff <= csr_wdata;
               default: begin
                  sw_ff <= sw_ff;
               end
            endcase
         end
         active_ff <= active_in;
         start_ff  <= start_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         rows_ff   <= rows_in;
         width_ff  <= width_in;
         pitch_ff  <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
      res_done_ff   <= res_done_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      if (cmd.div_load) begin
         rem_ff <= '0;
         case (tlprw_pkg::div_sel_type'(cmd.div_sel))
            tlprw_pkg::DIV_X_BY_MW: begin
               quo_ff <= x_ff;
               dvs_ff <= eff_mw;
            end
            tlprw_pkg::DIV_Y_BY_MH: begin
               quo_ff <= XW'(y_ff);
               dvs_ff <= eff_mh;
            end
            tlprw_pkg::DIV_SW_BY_MW: begin
               quo_ff <= XW'(eff_sw);
               dvs_ff <= eff_mw;
            end
            default: begin
               quo_ff <= '0;
               dvs_ff <= eff_mw;
            end
         endcase
      end else if (cmd.div_step) begin
         if (!trial[XW]) begin
            rem_ff <= trial[XW-1:0];
            quo_ff <= {quo_ff[XW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[XW-2:0], 1'b0};
         end
      end
      if (cmd.div_save) begin
         case (tlprw_pkg::div_sel_type'(cmd.div_sel))
            tlprw_pkg::DIV_X_BY_MW: begin
               tx_ff <= quo_ff;
               rx_ff <= rem_ff[DW-1:0];
            end
            tlprw_pkg::DIV_Y_BY_MH: begin
               ty_ff <= quo_ff;
               ry_ff <= rem_ff[DW-1:0];
            end
            tlprw_pkg::DIV_SW_BY_MW: begin
               per_row_ff <= quo_ff;
            end
            default: begin
               per_row_ff <= per_row_ff;
            end
         endcase
      end
      if (cmd.mul_step) begin
         case (tlprw_pkg::mul_sel_type'(cmd.mul_sel))
            tlprw_pkg::MUL_TILE: tile_ff <= mul_out;
            tlprw_pkg::MUL_AREA: area_ff <= mul_out;
            tlprw_pkg::MUL_PART: part_ff <= mul_out;
            tlprw_pkg::MUL_POS:  pos_ff  <= mul_out;
            default: begin
               tile_ff <= tile_ff;
            end
         endcase
      end
      if (cmd.push) begin
         out_kind_ff   <= res_kind_ff;
         out_status_ff <= res_status_ff;
         out_done_ff   <= res_done_ff;
         out_pos_ff    <= pos_ff;
         out_red_ff    <= red_ff;
         out_green_ff  <= green_ff;
         out_blue_ff   <= blue_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_strip_index = (out_kind_ff == tlprw_pkg::KIND_PIXEL) ? out_pos_ff : '0;
   assign rsp_red         = out_red_ff;
   assign rsp_green       = out_green_ff;
   assign rsp_blue        = out_blue_ff;
   assign rsp_frame_done  = out_done_ff;

endmodule

>>> rtl/tiled_led_panel_rect_writer_core.sv
`timescale 1ns / 1ps
// Rectangle writer for a panel tiled from row-major LED modules.
// The req channel takes words: a begin word (cmd 0) with origin, width, height and
// pitch, then pixel words (cmd 1) row by row, pitch words per row. Every begin
// returns one status word on the rsp channel; every visible pixel word returns one
// pixel word with its strip index and red, green and blue bytes. Padding words and
// pixel words that arrive while no write is open return nothing.
// A begin word's status passes through the result register and then the rsp
// register. The next word is taken only once the result is pushed. A visible pixel
// word keeps the block busy from acceptance to the next acceptance: a shared 10-step
// serial divider runs three divisions (x and y by the module size, modules per row),
// then a shared 16-bit multiplier takes four steps. Padding and dropped words do not
// leave idle. The csr port writes one of the four geometry registers per write.
// Reset restores the default geometry, closes any open write and empties the
// rsp register. While rsp_ready is low the finished word holds in its register;
// the block still accepts the next req word and works on it, and waits only when
// its own result is ready and the rsp register is still full.

module tiled_led_panel_rect_writer_core #(
   parameter int MAX_DIM = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [tlprw_pkg::COORD_W-1:0] req_origin_x,
   input  logic [tlprw_pkg::COORD_W-1:0] req_origin_y,
   input  logic [tlprw_pkg::DIM_W-1:0]   req_rect_width,
   input  logic [tlprw_pkg::DIM_W-1:0]   req_rect_height,
   input  logic [tlprw_pkg::DIM_W-1:0]   req_rect_pitch,
   input  logic [tlprw_pkg::WORD_W-1:0]  req_color_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic                          rsp_status,
   output logic [tlprw_pkg::POS_W-1:0]   rsp_strip_index,
   output logic [tlprw_pkg::BYTE_W-1:0]  rsp_red,
   output logic [tlprw_pkg::BYTE_W-1:0]  rsp_green,
   output logic [tlprw_pkg::BYTE_W-1:0]  rsp_blue,
   output logic                          rsp_frame_done,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [tlprw_pkg::DIM_W-1:0]   csr_wdata
);

   tlprw_pkg::cmd_type  cmd;
   tlprw_pkg::stat_type stat;

   tlprw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tlprw_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_rect_pitch  (req_rect_pitch),
      .req_color_word  (req_color_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_strip_index (rsp_strip_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_frame_done  (rsp_frame_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

>>> rtl/tlprw_checker.sv
`timescale 1ns / 1ps

module tlprw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_kind,
   input logic                         rsp_status,
   input logic [tlprw_pkg::POS_W-1:0]  rsp_strip_index,
   input logic [tlprw_pkg::BYTE_W-1:0] rsp_red,
   input logic [tlprw_pkg::BYTE_W-1:0] rsp_green,
   input logic [tlprw_pkg::BYTE_W-1:0] rsp_blue,
   input logic                         rsp_frame_done
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == tlprw_pkg::KIND_STATUS |->
         rsp_strip_index == '0 && rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("status word carries pixel data");

   a_reject_no_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == tlprw_pkg::KIND_STATUS
         && rsp_status == tlprw_pkg::STATUS_BAD |-> !rsp_frame_done)
      else $error("rejected rectangle flagged frame done");

   a_pixel_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == tlprw_pkg::KIND_PIXEL |->
         rsp_status == tlprw_pkg::STATUS_OK)
      else $error("pixel word with error status");

endmodule

bind tiled_led_panel_rect_writer_core tlprw_checker u_tlprw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_status      (rsp_status),
   .rsp_strip_index (rsp_strip_index),
   .rsp_red         (rsp_red),
   .rsp_green       (rsp_green),
   .rsp_blue        (rsp_blue),
   .rsp_frame_done  (rsp_frame_done)
);
